@@ rtl/thick_line_point_quad_expander_core_assert.svh @@
// assertion macros for the thick line point quad expander
`ifndef THICK_LINE_POINT_QUAD_EXPANDER_CORE_ASSERT_SVH
`define THICK_LINE_POINT_QUAD_EXPANDER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TLQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLQ_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLQ_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLQ_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/tlq_pkg.sv @@
// shared types and constants for the thick line point quad expander
`timescale 1ns / 1ps
package tlq_pkg;
  localparam int MaxVerts = 65536;
  localparam int CntW = 17;
  localparam int CoordW = 20;
  localparam int WidthW = 12;
  localparam int SqW = 58;
  localparam int RootW = 29;
  localparam int NumW = 50;
  localparam int QuoW = 22;

  localparam logic [1:0] CMD_LINE  = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  localparam logic signed [CoordW-1:0] CoordMax = 20'sh7FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = -20'sh80000;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic                     close_line;
    logic [31:0]              rgba;
    logic [WidthW-1:0]        width;
  } tlq_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vert_x;
    logic signed [CoordW-1:0] vert_y;
    logic [31:0]              vert_rgba;
    logic                     end_of_run;
    logic                     flush_done;
    logic [CntW-1:0]          batch_count;
  } tlq_out_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic seg_start;
    logic seg_second;
    logic sq_setup;
    logic step;
    logic vert_load;
    logic [2:0] vert_idx;
    logic vert_last;
    logic flush_load;
    logic line_begin;
    logic line_update;
    logic line_close;
    logic add_six;
  } tlq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic busy;
    logic line_open;
    logic room;
    logic [1:0] cmd;
    logic close_line;
  } tlq_stat_t;

  function automatic logic signed [CoordW-1:0] sat20(input logic signed [22:0] v);
    if (v > 23'(CoordMax)) return CoordMax;
    if (v < 23'(CoordMin)) return CoordMin;
    return v[CoordW-1:0];
  endfunction
endpackage

@@ rtl/tlq_if.sv @@
// valid ready channel interface
`timescale 1ns / 1ps
interface tlq_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/tlq_datapath.sv @@
// datapath: line state, square root and divide units, vertex build
`timescale 1ns / 1ps
module tlq_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tlq_pkg::tlq_in_t    in_data,
  input  tlq_pkg::tlq_cmd_t   ctl,
  output tlq_pkg::tlq_stat_t  stat,
  output tlq_pkg::tlq_out_t   vert
);
  import tlq_pkg::*;

  tlq_in_t item_r;
  logic signed [CoordW-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic line_open_r;
  logic [CntW-1:0] total_r;

  // segment endpoints
  logic signed [CoordW-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [CoordW:0] adx_r, ady_r;
  logic sdx_r, sdy_r;
  logic [SqW-1:0] rad_r, rem_r;
  logic [RootW-1:0] root_r;
  logic [4:0] rcnt_r;
  logic [NumW-1:0] numx_r, numy_r;
  logic [QuoW-1:0] qx_r, qy_r;
  logic [5:0] dcnt_r;
  logic [1:0] phase_r;  // 0 idle 1 mult 2 sqrt 3 divide
  logic [NumW:0] remx_r, remy_r;
  logic signed [22:0] nx_r, ny_r;
  logic zero_r;
  tlq_out_t vert_r;

  logic signed [CoordW:0] dx, dy;
  logic [SqW-1:0] sq;
  logic [RootW:0] div2;
  logic [NumW:0] tx, ty;
  logic [31:0] px, py;

  // segment setup differences
  always_comb begin
    if (ctl.seg_second) begin
      dx = 21'(first_x_r) - 21'(item_r.pos_x);
      dy = 21'(first_y_r) - 21'(item_r.pos_y);
    end else begin
      dx = 21'(item_r.pos_x) - 21'(prev_x_r);
      dy = 21'(item_r.pos_y) - 21'(prev_y_r);
    end
  end

  assign sq = 58'(adx_r) * 58'(adx_r) + 58'(ady_r) * 58'(ady_r);
  assign div2 = {root_r, 1'b0};
  assign px = 32'(adx_r) * 32'(item_r.width);
  assign py = 32'(ady_r) * 32'(item_r.width);
  assign tx = {remx_r[NumW-1:0], numx_r[NumW-1]};
  assign ty = {remy_r[NumW-1:0], numy_r[NumW-1]};

  // iterative units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      line_open_r <= 1'b0;
      total_r <= '0;
      first_x_r <= '0; first_y_r <= '0; prev_x_r <= '0; prev_y_r <= '0;
    end else begin
      if (ctl.load_in) item_r <= in_data;
      if (ctl.line_begin) begin
        first_x_r <= item_r.pos_x; first_y_r <= item_r.pos_y;
        prev_x_r <= item_r.pos_x; prev_y_r <= item_r.pos_y;
        line_open_r <= !item_r.close_line;
      end
      if (ctl.line_update) begin
        prev_x_r <= item_r.pos_x; prev_y_r <= item_r.pos_y;
      end
      if (ctl.line_close) line_open_r <= 1'b0;
      if (ctl.add_six) total_r <= total_r + CntW'(6);
      if (ctl.flush_load) total_r <= '0;
      if (ctl.seg_start) begin
        if (ctl.seg_second) begin
          x0_r <= item_r.pos_x; y0_r <= item_r.pos_y;
          x1_r <= first_x_r; y1_r <= first_y_r;
        end else begin
          x0_r <= prev_x_r; y0_r <= prev_y_r;
          x1_r <= item_r.pos_x; y1_r <= item_r.pos_y;
        end
        adx_r <= dx[CoordW] ? 21'(-dx) : 21'(dx);
        ady_r <= dy[CoordW] ? 21'(-dy) : 21'(dy);
        sdx_r <= dx[CoordW];
        sdy_r <= (dy > 0);
        phase_r <= 2'd1;
      end else if (phase_r == 2'd1) begin
        // radicand is s * 65536, top aligned
        rad_r <= sq << 16;
        zero_r <= (sq == '0);
        rem_r <= '0; root_r <= '0; rcnt_r <= 5'd0;
        numx_r <= NumW'(py) << 8;
        numy_r <= NumW'(px) << 8;
        phase_r <= 2'd2;
      end else if (phase_r == 2'd2) begin
        // one root bit per step on s*65536, two radicand bits at a time
        logic [SqW-1:0] r2;
        r2 = {rem_r[SqW-3:0], (rcnt_r < 5'd21) ? rad_r[SqW-1:SqW-2] : 2'b00};
        if (r2 >= {root_r, 2'b01}) begin
          rem_r <= r2 - {root_r, 2'b01};
          root_r <= {root_r[RootW-2:0], 1'b1};
        end else begin
          rem_r <= r2;
          root_r <= {root_r[RootW-2:0], 1'b0};
        end
        rad_r <= rad_r << 2;
        rcnt_r <= rcnt_r + 5'd1;
        if (rcnt_r == 5'(RootW - 1)) begin
          phase_r <= 2'd3; dcnt_r <= 6'd0;
        end
      end else if (phase_r == 2'd3) begin
        if (dcnt_r == 6'd0) begin
          // add rounding term once
          numx_r <= numx_r + NumW'(root_r);
          numy_r <= numy_r + NumW'(root_r);
          remx_r <= '0; remy_r <= '0;
          dcnt_r <= 6'd1;
        end else begin
          if (tx >= (NumW+1)'(div2)) begin
            remx_r <= tx - (NumW+1)'(div2); numx_r <= {numx_r[NumW-2:0], 1'b1};
          end else begin
            remx_r <= tx; numx_r <= {numx_r[NumW-2:0], 1'b0};
          end
          if (ty >= (NumW+1)'(div2)) begin
            remy_r <= ty - (NumW+1)'(div2); numy_r <= {numy_r[NumW-2:0], 1'b1};
          end else begin
            remy_r <= ty; numy_r <= {numy_r[NumW-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'(NumW)) begin
            phase_r <= 2'd0;
            nx_r <= zero_r ? '0 : (sdy_r ? -23'({numx_r[QuoW-2:0], tx >= (NumW+1)'(div2)})
                                        : 23'({numx_r[QuoW-2:0], tx >= (NumW+1)'(div2)}));
            ny_r <= zero_r ? '0 : (sdx_r ? -23'({numy_r[QuoW-2:0], ty >= (NumW+1)'(div2)})
                                        : 23'({numy_r[QuoW-2:0], ty >= (NumW+1)'(div2)}));
          end
        end
      end
      if (ctl.sq_setup) begin
        x0_r <= item_r.pos_x; y0_r <= item_r.pos_y;
      end
    end
  end

  // vertex corners
  logic signed [22:0] cx0, cx1, cy0, cy1, hw;
  logic signed [22:0] vx, vy;
  always_comb begin
    hw = 23'({1'b0, item_r.width[WidthW-1:1]});
    if (item_r.cmd == CMD_POINT) begin
      cx0 = 23'(x0_r) - hw; cy0 = 23'(y0_r) - hw;
      cx1 = cx0 + 23'(item_r.width); cy1 = cy0 + 23'(item_r.width);
      unique case (ctl.vert_idx)
        3'd0, 3'd5: begin vx = cx0; vy = cy0; end
        3'd1:       begin vx = cx1; vy = cy0; end
        3'd2, 3'd3: begin vx = cx1; vy = cy1; end
        3'd4:       begin vx = cx0; vy = cy1; end
        default:    begin vx = cx0; vy = cy0; end
      endcase
    end else begin
      cx0 = '0; cy0 = '0; cx1 = '0; cy1 = '0;
      unique case (ctl.vert_idx)
        3'd0, 3'd5: begin vx = 23'(x0_r) + nx_r; vy = 23'(y0_r) + ny_r; end
        3'd1:       begin vx = 23'(x1_r) + nx_r; vy = 23'(y1_r) + ny_r; end
        3'd2, 3'd3: begin vx = 23'(x1_r) - nx_r; vy = 23'(y1_r) - ny_r; end
        3'd4:       begin vx = 23'(x0_r) - nx_r; vy = 23'(y0_r) - ny_r; end
        default:    begin vx = 23'(x0_r); vy = 23'(y0_r); end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ctl.vert_load) begin
      vert_r.vert_x <= sat20(vx);
      vert_r.vert_y <= sat20(vy);
      vert_r.vert_rgba <= item_r.rgba;
      vert_r.end_of_run <= ctl.vert_last;
      vert_r.flush_done <= 1'b0;
      vert_r.batch_count <= '0;
    end else if (ctl.flush_load) begin
      vert_r <= '{vert_x: '0, vert_y: '0, vert_rgba: '0, end_of_run: 1'b1,
                  flush_done: 1'b1, batch_count: total_r};
    end
  end

  assign vert = vert_r;
  assign stat.busy = (phase_r != 2'd0) || ctl.seg_start;
  assign stat.line_open = line_open_r;
  assign stat.room = (18'(total_r) + 18'd6) < 18'(MaxVerts);
  assign stat.cmd = item_r.cmd;
  assign stat.close_line = item_r.close_line;

  `include "thick_line_point_quad_expander_core_assert.svh"
  `TLQ_ASSERT(a_count_step, clk, rst_n, ctl.add_six |=> (total_r == $past(total_r) + 17'd6), "count")
  `TLQ_ASSERT(a_flush_clear, clk, rst_n, ctl.flush_load |=> (total_r == '0), "flush clear")
  `TLQ_ASSERT(a_no_overlap, clk, rst_n, !(ctl.vert_load && ctl.flush_load), "load clash")
endmodule

@@ rtl/tlq_ctrl.sv @@
// controller state machine sequencing segments and vertices
`timescale 1ns / 1ps
module tlq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  tlq_pkg::tlq_stat_t stat,
  output tlq_pkg::tlq_cmd_t  ctl
);
  import tlq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_SEG = 3'd2, S_WAIT = 3'd3,
                         S_EMIT = 3'd4, S_OUT = 3'd5, S_FL = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic second_r, second_nxt;
  logic ov_r, ov_nxt;
  logic last_seg;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign last_seg = (stat.cmd == CMD_POINT) || !(stat.close_line && !second_r);

  // sequencing
  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r; second_nxt = second_r;
    ov_nxt = ov_r && !out_ready;
    ctl = '0;
    ctl.vert_idx = idx_r;
    ctl.seg_second = second_r;
    unique case (state_r)
      S_IDLE: if (in_valid && in_ready) begin
        ctl.load_in = 1'b1; state_nxt = S_DEC;
      end
      S_DEC: begin
        second_nxt = 1'b0;
        unique case (stat.cmd)
          CMD_LINE: if (!stat.line_open) begin
            ctl.line_begin = 1'b1; state_nxt = S_IDLE;
          end else state_nxt = S_SEG;
          CMD_POINT: begin
            ctl.sq_setup = 1'b1; idx_nxt = 3'd0;
            state_nxt = stat.room ? S_EMIT : S_IDLE;
            if (stat.room) ctl.add_six = 1'b1;
          end
          CMD_FLUSH: state_nxt = S_FL;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SEG: begin
        ctl.seg_start = 1'b1; state_nxt = S_WAIT;
      end
      S_WAIT: if (!stat.busy) begin
        idx_nxt = 3'd0;
        if (stat.room) begin
          ctl.add_six = 1'b1; state_nxt = S_EMIT;
        end else if (!last_seg) begin
          second_nxt = 1'b1; state_nxt = S_SEG;
        end else begin
          ctl.line_update = 1'b1; ctl.line_close = stat.close_line; state_nxt = S_IDLE;
        end
      end
      S_EMIT: if (!ov_r || out_ready) begin
        ctl.vert_load = 1'b1;
        // a closing segment that will not fit makes this quad the last one
        ctl.vert_last = (idx_r == 3'd5) && (last_seg || !stat.room);
        ov_nxt = 1'b1;
        idx_nxt = idx_r + 3'd1;
        if (idx_r == 3'd5) begin
          if (!last_seg) begin
            second_nxt = 1'b1; state_nxt = S_SEG;
          end else begin
            state_nxt = S_OUT;
            if (stat.cmd == CMD_LINE) begin
              ctl.line_update = 1'b1; ctl.line_close = stat.close_line;
            end
          end
        end
      end
      S_OUT: state_nxt = S_IDLE;
      S_FL: if (!ov_r || out_ready) begin
        ctl.flush_load = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; idx_r <= '0; second_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt; second_r <= second_nxt; ov_r <= ov_nxt;
    end
  end

  `include "thick_line_point_quad_expander_core_assert.svh"
  `TLQ_ASSERT(a_hold_emit, clk, rst_n, (ov_r && !out_ready) |-> !ctl.vert_load, "overwrite")
  `TLQ_ASSERT(a_idle_accept, clk, rst_n, ctl.load_in |-> (state_r == S_IDLE), "accept")
  `TLQ_ASSERT(a_idx_range, clk, rst_n, ctl.vert_load |-> (idx_r <= 3'd5), "index")
endmodule

@@ rtl/thick_line_point_quad_expander_core.sv @@
// top level of the thick line point quad expander
// Usage: items arrive on the in channel (valid/ready, one request per item:
// cmd, pos_x, pos_y, close_line, rgba, width). Results leave on the out
// channel, six vertices per quad or a flush report, end_of_run marking the
// last result of an item.
// Sequence: a polyline segment needs a setup (segment start, then squares),
// a 29-step square root and a 51-step divide on the shared segment unit,
// then six vertices; a closing point runs the unit twice.
// One item is processed at a time; the next is taken while the last result
// may still wait in the output register.
// Reset (synchronous, rst_n low) clears the polyline state, the vertex
// count and any pending result.
// A stalled receiver holds the output register; the sequencer waits.
`timescale 1ns / 1ps
module thick_line_point_quad_expander_core (
  input logic clk,
  input logic rst_n,
  tlq_if.sink   in_ch,
  tlq_if.source out_ch
);
  import tlq_pkg::*;

  tlq_cmd_t  ctl;
  tlq_stat_t stat;
  tlq_out_t  vert;

  tlq_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .stat, .ctl
  );

  tlq_datapath u_dp (
    .clk, .rst_n, .in_data(in_ch.data), .ctl, .stat, .vert
  );

  assign out_ch.data = vert;
endmodule
